// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file pcrs_checker.sv.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/pcrs_pkg.sv -----
// Package for the pending command retry scheduler: command codes, FSM type,
// controller/datapath interface structs. No dependencies.
`timescale 1ns / 1ps

package pcrs_pkg;

    localparam int CODE_W  = 6;
    localparam int CMD_W   = 2;
    localparam int RETRY_W = 4;

    localparam logic [CMD_W-1:0] CMD_POST   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESEND = 2'd2;

    localparam logic [RETRY_W-1:0] RETRY_LIMIT_RST = 4'd3;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_HOLD = 2'b10
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // register the outcome of this transaction
        logic post;      // set bit, make code current, reload counter
        logic drop;      // clear current bit, pick lowest pending, reload counter
        logic dec;       // decrement counter, request resend
    } dp_ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic code_ok;
        logic retry_zero;
        logic pending_nz;
    } dp_stat_t;

endpackage

// ----- sv/pcrs_datapath.sv -----
// Datapath: pending bitmap, current code, retry counter, retry_limit register.
// Depends on pcrs_pkg.
`timescale 1ns / 1ps

module pcrs_datapath #(
    parameter int NUM_CODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pcrs_pkg::RETRY_W-1:0]  cfg_wr_data,
    input  logic [pcrs_pkg::CODE_W-1:0]   code,
    input  pcrs_pkg::dp_ctl_t             ctl,
    output pcrs_pkg::dp_stat_t            stat,
    output logic                          send,
    output logic [pcrs_pkg::CODE_W-1:0]   send_code,
    output logic                          pending_any,
    output logic [pcrs_pkg::RETRY_W-1:0]  retries_left
);
    import pcrs_pkg::*;

    logic [RETRY_W-1:0]   limit_reg;
    logic [NUM_CODES-1:0] pending_reg, pending_next;
    logic [CODE_W-1:0]    current_reg, current_next;
    logic [RETRY_W-1:0]   retry_reg, retry_next;
    logic                 send_reg, send_next;

    logic [NUM_CODES-1:0] posted;
    logic [NUM_CODES-1:0] cleared;
    logic [CODE_W-1:0]    first_idx;
    logic                 cleared_nz;

    always_comb
    begin
        posted  = pending_reg;
        cleared = pending_reg;
        for (int i = 0; i < NUM_CODES; i++)
        begin
            if (CODE_W'(i) == code)
            begin
                posted[i] = 1'b1;
            end
            if (CODE_W'(i) == current_reg)
            begin
                cleared[i] = 1'b0;
            end
        end
    end

    // lowest set bit of the bitmap after the current code is removed
    always_comb
    begin
        first_idx = '0;
        for (int i = NUM_CODES - 1; i >= 0; i--)
        begin
            if (cleared[i])
            begin
                first_idx = CODE_W'(i);
            end
        end
    end

    assign cleared_nz = |cleared;

    always_comb
    begin
        pending_next = pending_reg;
        current_next = current_reg;
        retry_next   = retry_reg;
        send_next    = 1'b0;
        if (ctl.post)
        begin
            pending_next = posted;
            current_next = code;
            retry_next   = limit_reg;
            send_next    = 1'b1;
        end
        else if (ctl.drop)
        begin
            pending_next = cleared;
            current_next = cleared_nz ? first_idx : '0;
            retry_next   = limit_reg;
            send_next    = cleared_nz;
        end
        else if (ctl.dec)
        begin
            retry_next = retry_reg - 4'd1;
            send_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg   <= RETRY_LIMIT_RST;
            pending_reg <= '0;
            current_reg <= '0;
            retry_reg   <= '0;
            send_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                limit_reg <= cfg_wr_data;
            end
            if (ctl.capture)
            begin
                pending_reg <= pending_next;
                current_reg <= current_next;
                retry_reg   <= retry_next;
                send_reg    <= send_next;
            end
        end
    end

    assign stat.code_ok    = {1'b0, code} < (CODE_W + 1)'(NUM_CODES);
    assign stat.retry_zero = (retry_reg == '0);
    assign stat.pending_nz = |pending_reg;

    assign send         = send_reg;
    assign send_code    = current_reg;
    assign pending_any  = |pending_reg;
    assign retries_left = retry_reg;

endmodule

// ----- sv/pcrs_ctrl.sv -----
// Controller: handshake state machine and command decode into datapath controls.
// Depends on pcrs_pkg.
`timescale 1ns / 1ps

module pcrs_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  logic [pcrs_pkg::CMD_W-1:0]  cmd,
    input  pcrs_pkg::dp_stat_t          stat,
    output pcrs_pkg::dp_ctl_t           ctl
);
    import pcrs_pkg::*;

    state_t state_reg, state_next;
    logic   take;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_HOLD);
    assign take      = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.capture = take;
        unique case (cmd)
            CMD_POST:   ctl.post = take && stat.code_ok;
            CMD_ACK:    ctl.drop = take;
            CMD_RESEND:
            begin
                ctl.drop = take && stat.retry_zero;
                ctl.dec  = take && !stat.retry_zero && stat.pending_nz;
            end
            default:    ctl.capture = take;   // unused command: report state only
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- sv/pending_command_retry_scheduler.sv -----
// Pending command retry scheduler.
// Input channel (in_valid/in_ready) carries cmd and code: post, acknowledge,
// or resend request. Output channel (out_valid/out_ready) carries one result
// per transaction: send, send_code, pending_any, retries_left.
// cfg_wr_en/cfg_wr_data write retry_limit (reset 3); write only while idle.
// Latency: result valid the cycle after the input transaction.
// One transaction at a time; the controller takes a new input only after the
// previous result is taken.
// The 64-bit priority encoder and counter update complete in the accept cycle.
// Reset: bitmap, current code and counter clear, no result pending, in_ready high.
// While the receiver stalls, the result holds and in_ready stays low.
// Depends on pcrs_pkg, pcrs_ctrl, pcrs_datapath.
`timescale 1ns / 1ps

module pending_command_retry_scheduler #(
    parameter int NUM_CODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pcrs_pkg::RETRY_W-1:0]  cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [pcrs_pkg::CMD_W-1:0]    cmd,
    input  logic [pcrs_pkg::CODE_W-1:0]   code,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          send,
    output logic [pcrs_pkg::CODE_W-1:0]   send_code,
    output logic                          pending_any,
    output logic [pcrs_pkg::RETRY_W-1:0]  retries_left
);
    import pcrs_pkg::*;

    dp_ctl_t  ctl;
    dp_stat_t stat;

    pcrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat),
        .ctl       (ctl)
    );

    pcrs_datapath #(
        .NUM_CODES (NUM_CODES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .code         (code),
        .ctl          (ctl),
        .stat         (stat),
        .send         (send),
        .send_code    (send_code),
        .pending_any  (pending_any),
        .retries_left (retries_left)
    );

endmodule

// ----- sv/pcrs_checker.sv -----
// Port-level checker for pending_command_retry_scheduler, bound to the top level.
// Depends on pcrs_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrs_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          send,
    input logic [pcrs_pkg::CODE_W-1:0]   send_code,
    input logic                          pending_any
);
    import pcrs_pkg::*;

    // one transaction in flight: no input taken while a result waits
    `ASSERT_IMPL(a_one_in_flight, out_valid, !in_ready, "input ready while result pending")
    // every input transaction produces a result next cycle
    `ASSERT_NEXT(a_result_follows, in_valid && in_ready, out_valid, "no result after input")
    // a stalled result stays put
    `ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(send_code),
        "stalled result changed")
    // a send is requested only while something is pending
    `ASSERT_IMPL(a_send_pending, out_valid && send, pending_any, "send with empty bitmap")
    // empty bitmap means nothing current
    `ASSERT_IMPL(a_empty_code0, out_valid && !pending_any, send_code == '0,
        "current code with empty bitmap")

endmodule

bind pending_command_retry_scheduler pcrs_checker u_pcrs_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .send        (send),
    .send_code   (send_code),
    .pending_any (pending_any)
);
